// ===== rtl/lru_page_table_translate_top_macros.svh =====
// Assertion macros for the LRU page table translator.
// Included by the RTL files that carry assertions; expects aclk and aresetn in scope.
`ifndef LRU_PAGE_TABLE_TRANSLATE_TOP_MACROS_SVH
`define LRU_PAGE_TABLE_TRANSLATE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LPT_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("lpt assertion failed");
`define LPT_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("lpt assertion failed");
`else
`define LPT_ASSERT(label, prop)
`define LPT_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ===== rtl/lpt_pkg.sv =====
// Shared constants and types for the LRU page table translator.
// No dependencies; used by every module of the block.
package lpt_pkg;

    localparam int VA_WIDTH       = 12;
    localparam int PA_WIDTH       = 10;
    localparam int OFFSET_WIDTH   = 7;
    localparam int PAGE_NUM_WIDTH = VA_WIDTH - OFFSET_WIDTH;
    localparam int STAMP_WIDTH    = 32;
    localparam int COUNT_WIDTH    = 32;

    localparam int PAGES_DEF  = 32;
    localparam int FRAMES_DEF = 8;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;

    typedef struct packed {
        logic clear;
        logic cmp_en;
    } scan_ctrl_t;

endpackage

// ===== rtl/lru_page_table_translate_top.sv =====
// LRU page table translator, top level: sequencer, counters and output register.
// Depends on lpt_pkg, lpt_table, lpt_lru_scan and the assertion macro header.
// A hit, or a miss while unused frames remain, passes through CHECK and FINISH back to IDLE;
// a miss once all frames are used also passes through SCAN and EVICT, where the victim
// search reads the table memory through its single read port one entry per cycle and
// feeds one shared stamp comparator. s_tready is high only while the block is idle; a finished
// item waits in the output register and does not block the next accept.
`include "lru_page_table_translate_top_macros.svh"

module lru_page_table_translate_top #(
    parameter int PAGES  = lpt_pkg::PAGES_DEF,
    parameter int FRAMES = lpt_pkg::FRAMES_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lpt_pkg::S_TDATA_W-1:0] s_tdata,  // [11:0] virtual_address
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lpt_pkg::M_TDATA_W-1:0] m_tdata,  // [9:0] physical_address, [41:10] fault_total
    output logic [lpt_pkg::M_TUSER_W-1:0] m_tuser   // [0] page_fault, [1] evicted
);

    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int NFF_W   = $clog2(FRAMES + 1);
    localparam int SCAN_W  = $clog2(PAGES + 1);
    localparam int OW      = lpt_pkg::OFFSET_WIDTH;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_EVICT  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [NFF_W-1:0]                nff_reg, nff_next;
    logic [lpt_pkg::STAMP_WIDTH-1:0] stamp_reg, stamp_next;
    logic [lpt_pkg::COUNT_WIDTH-1:0] fault_cnt_reg, fault_cnt_next;
    logic [SCAN_W-1:0]               scan_idx_reg, scan_idx_next;
    logic                            cmp_en_reg, cmp_en_next;
    logic [PAGE_W-1:0]               cmp_idx_reg;
    logic                            m_tvalid_reg, m_tvalid_next;

    logic [PAGE_W-1:0]               page_reg;
    logic [OW-1:0]                   offset_reg;
    logic [FRAME_W-1:0]              frame_reg;
    logic                            fault_reg;
    logic                            evict_reg;

    logic [lpt_pkg::PA_WIDTH-1:0]    pa_out_reg;
    logic [lpt_pkg::COUNT_WIDTH-1:0] total_out_reg;
    logic                            fault_out_reg;
    logic                            evict_out_reg;

    logic [PAGE_W-1:0]               page_map [2**lpt_pkg::PAGE_NUM_WIDTH];
    logic [PAGE_W-1:0]               page_in;
    logic                            accept;
    logic                            out_load;
    logic                            scan_done;
    logic                            nff_free;

    logic [PAGE_W-1:0]               rd_addr;
    logic [FRAME_W-1:0]              rd_frame;
    logic [lpt_pkg::STAMP_WIDTH-1:0] rd_stamp;
    logic [PAGES-1:0]                valid;
    logic                            wr_en;
    logic                            clr_en;

    lpt_pkg::scan_ctrl_t             scan_ctrl;
    logic                            best_found;
    logic [PAGE_W-1:0]               best_idx;
    logic [FRAME_W-1:0]              best_frame;

    for (genvar g = 0; g < 2**lpt_pkg::PAGE_NUM_WIDTH; g++) begin : g_page_map
        assign page_map[g] = PAGE_W'(g % PAGES);
    end

    assign page_in   = page_map[s_tdata[lpt_pkg::VA_WIDTH-1:OW]];
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);
    assign scan_done = (scan_idx_reg == SCAN_W'(PAGES)) && cmp_en_reg;
    assign nff_free  = (nff_reg < NFF_W'(FRAMES));
    assign wr_en     = out_load;
    assign clr_en    = (state_reg == ST_EVICT) && best_found;

    assign scan_ctrl.clear  = (state_reg == ST_CHECK);
    assign scan_ctrl.cmp_en = cmp_en_reg;

    always_comb begin
        case (state_reg)
            ST_IDLE: rd_addr = page_in;
            ST_SCAN: rd_addr = scan_idx_reg[PAGE_W-1:0];
            default: rd_addr = page_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        nff_next       = nff_reg;
        stamp_next     = stamp_reg;
        fault_cnt_next = fault_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_en_next    = 1'b0;
        m_tvalid_next  = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (valid[page_reg]) begin
                    state_next = ST_FINISH;
                end else begin
                    fault_cnt_next = fault_cnt_reg + 1'b1;
                    if (nff_free) begin
                        nff_next   = nff_reg + 1'b1;
                        state_next = ST_FINISH;
                    end else begin
                        scan_idx_next = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_idx_reg != SCAN_W'(PAGES)) begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                    cmp_en_next   = 1'b1;
                end
                if (scan_done) begin
                    state_next = ST_EVICT;
                end
            end
            ST_EVICT: begin
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_load) begin
                    stamp_next    = stamp_reg + 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            nff_reg       <= '0;
            stamp_reg     <= '0;
            fault_cnt_reg <= '0;
            scan_idx_reg  <= '0;
            cmp_en_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            nff_reg       <= nff_next;
            stamp_reg     <= stamp_next;
            fault_cnt_reg <= fault_cnt_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_en_reg    <= cmp_en_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= scan_idx_reg[PAGE_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    page_reg   <= page_in;
                    offset_reg <= s_tdata[OW-1:0];
                end
            end
            ST_CHECK: begin
                evict_reg <= 1'b0;
                if (valid[page_reg]) begin
                    frame_reg <= rd_frame;
                    fault_reg <= 1'b0;
                end else begin
                    frame_reg <= FRAME_W'(nff_reg);
                    fault_reg <= 1'b1;
                end
            end
            ST_EVICT: begin
                frame_reg <= best_found ? best_frame : '0;
                evict_reg <= best_found;
            end
            ST_FINISH: begin
                if (out_load) begin
                    pa_out_reg    <= lpt_pkg::PA_WIDTH'({frame_reg, offset_reg});
                    total_out_reg <= fault_cnt_reg;
                    fault_out_reg <= fault_reg;
                    evict_out_reg <= evict_reg;
                end
            end
            default: begin
            end
        endcase
    end

    lpt_table #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_table (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_addr  (rd_addr),
        .rd_frame (rd_frame),
        .rd_stamp (rd_stamp),
        .wr_en    (wr_en),
        .wr_addr  (page_reg),
        .wr_frame (frame_reg),
        .wr_stamp (stamp_reg),
        .clr_en   (clr_en),
        .clr_addr (best_idx),
        .valid    (valid)
    );

    lpt_lru_scan #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (scan_ctrl),
        .entry_valid (valid[cmp_idx_reg]),
        .entry_idx   (cmp_idx_reg),
        .entry_frame (rd_frame),
        .entry_stamp (rd_stamp),
        .best_found  (best_found),
        .best_idx    (best_idx),
        .best_frame  (best_frame)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = lpt_pkg::M_TDATA_W'({total_out_reg, pa_out_reg});
    assign m_tuser  = {evict_out_reg, fault_out_reg};

    `LPT_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready)
    `LPT_ASSERT(a_evict_only_on_fault, m_tvalid && m_tuser[1] |-> m_tuser[0])
    `LPT_ASSERT(a_scan_only_when_full, state_reg == ST_SCAN |-> nff_reg == NFF_W'(FRAMES))
    `LPT_ASSERT(a_fault_count_step, state_reg == ST_CHECK && !valid[page_reg] |=> fault_cnt_reg == lpt_pkg::COUNT_WIDTH'($past(fault_cnt_reg) + 1'b1))
    `LPT_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> s_tready && !m_tvalid)

endmodule

// ===== rtl/lpt_table.sv =====
// Page table storage: valid flags in flops, frame and stamp in a memory with one read and one write port.
// Depends on lpt_pkg.
module lpt_table #(
    parameter int PAGES  = lpt_pkg::PAGES_DEF,
    parameter int FRAMES = lpt_pkg::FRAMES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [$clog2(PAGES)-1:0]         rd_addr,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rd_frame,
    output logic [lpt_pkg::STAMP_WIDTH-1:0]  rd_stamp,
    input  logic                             wr_en,
    input  logic [$clog2(PAGES)-1:0]         wr_addr,
    input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] wr_frame,
    input  logic [lpt_pkg::STAMP_WIDTH-1:0]  wr_stamp,
    input  logic                             clr_en,
    input  logic [$clog2(PAGES)-1:0]         clr_addr,
    output logic [PAGES-1:0]                 valid
);

    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int WORD_W  = FRAME_W + lpt_pkg::STAMP_WIDTH;

    logic [WORD_W-1:0] entry_ram [PAGES];
    logic [WORD_W-1:0] rd_data_reg;
    logic [PAGES-1:0]  valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            entry_ram[wr_addr] <= {wr_frame, wr_stamp};
        end
        rd_data_reg <= entry_ram[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (clr_en) begin
                valid_reg[clr_addr] <= 1'b0;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rd_frame = rd_data_reg[WORD_W-1:lpt_pkg::STAMP_WIDTH];
    assign rd_stamp = rd_data_reg[lpt_pkg::STAMP_WIDTH-1:0];
    assign valid    = valid_reg;

endmodule

// ===== rtl/lpt_lru_scan.sv =====
// Shared stamp comparator that tracks the oldest valid entry during a table sweep.
// Depends on lpt_pkg.
module lpt_lru_scan #(
    parameter int PAGES  = lpt_pkg::PAGES_DEF,
    parameter int FRAMES = lpt_pkg::FRAMES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  lpt_pkg::scan_ctrl_t              ctrl,
    input  logic                             entry_valid,
    input  logic [$clog2(PAGES)-1:0]         entry_idx,
    input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] entry_frame,
    input  logic [lpt_pkg::STAMP_WIDTH-1:0]  entry_stamp,
    output logic                             best_found,
    output logic [$clog2(PAGES)-1:0]         best_idx,
    output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] best_frame
);

    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic                            found_reg;
    logic [PAGE_W-1:0]               best_idx_reg;
    logic [FRAME_W-1:0]              best_frame_reg;
    logic [lpt_pkg::STAMP_WIDTH-1:0] best_stamp_reg;
    logic                            take;

    assign take = ctrl.cmp_en && entry_valid && (!found_reg || entry_stamp < best_stamp_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctrl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            best_idx_reg   <= entry_idx;
            best_frame_reg <= entry_frame;
            best_stamp_reg <= entry_stamp;
        end
    end

    assign best_found = found_reg;
    assign best_idx   = best_idx_reg;
    assign best_frame = best_frame_reg;

endmodule

// ===== dv/lru_page_table_translate_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for lru_page_table_translate_top: address streams in, translations out.
// Depends on lpt_pkg and the RTL of the block; predicts each translation with an LRU page model.
module lru_page_table_translate_top_test;

    localparam int NUM_PAGES   = lpt_pkg::PAGES_DEF;
    localparam int NUM_FRAMES  = lpt_pkg::FRAMES_DEF;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_ITEMS = 600;

    typedef struct packed {
        logic [lpt_pkg::PA_WIDTH-1:0]    phys_addr;
        logic                            fault;
        logic                            evicted;
        logic [lpt_pkg::COUNT_WIDTH-1:0] fault_total;
    } xlate_t;

    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_COIN   = 2'd1,
        RX_SPARSE = 2'd2,
        RX_MOSTLY = 2'd3
    } rx_mode_t;

    class xlate_scoreboard;
        logic                            page_valid[NUM_PAGES];
        logic [2:0]                      page_frame[NUM_PAGES];
        logic [lpt_pkg::STAMP_WIDTH-1:0] page_stamp[NUM_PAGES];
        logic [3:0]                      next_frame;
        logic [lpt_pkg::STAMP_WIDTH-1:0] use_stamp;
        logic [lpt_pkg::COUNT_WIDTH-1:0] faults;
        xlate_t                          pending_xlates[$];
        int                              errors;

        function new();
            foreach (page_valid[i]) begin
                page_valid[i] = 1'b0;
                page_frame[i] = '0;
                page_stamp[i] = '0;
            end
            next_frame = '0;
            use_stamp  = '0;
            faults     = '0;
            errors     = 0;
        endfunction

        function int pending();
            return pending_xlates.size();
        endfunction

        function void note_access(logic [lpt_pkg::VA_WIDTH-1:0] vaddr);
            logic [lpt_pkg::PAGE_NUM_WIDTH-1:0] page;
            logic [2:0]                         frame;
            logic [lpt_pkg::STAMP_WIDTH-1:0]    oldest;
            int                                 victim;
            xlate_t                             res;
            page = vaddr[lpt_pkg::VA_WIDTH-1:lpt_pkg::OFFSET_WIDTH];
            frame = '0;
            res.fault = 1'b0;
            res.evicted = 1'b0;
            if (page_valid[page]) begin
                frame = page_frame[page];
            end else begin
                res.fault = 1'b1;
                faults = faults + 1'b1;
                if (next_frame < NUM_FRAMES) begin
                    frame = next_frame[2:0];
                    next_frame = next_frame + 1'b1;
                end else begin
                    victim = -1;
                    oldest = '0;
                    for (int i = 0; i < NUM_PAGES; i++) begin
                        if (page_valid[i] && (victim < 0 || page_stamp[i] < oldest)) begin
                            victim = i;
                            oldest = page_stamp[i];
                        end
                    end
                    if (victim >= 0) begin
                        page_valid[victim] = 1'b0;
                        frame = page_frame[victim];
                        res.evicted = 1'b1;
                    end
                end
            end
            page_valid[page] = 1'b1;
            page_frame[page] = frame;
            page_stamp[page] = use_stamp;
            use_stamp = use_stamp + 1'b1;
            res.phys_addr = {frame, vaddr[lpt_pkg::OFFSET_WIDTH-1:0]};
            res.fault_total = faults;
            pending_xlates.push_back(res);
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            if (errors <= 50)
                $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        endtask

        task check_xlate(xlate_t got);
            xlate_t want;
            if (pending_xlates.size() == 0) begin
                report_mismatch("unexpected item", 32'(got.phys_addr), 32'(0));
            end else begin
                want = pending_xlates.pop_front();
                if (got.phys_addr !== want.phys_addr)
                    report_mismatch("physical_address", 32'(got.phys_addr),
                                    32'(want.phys_addr));
                if (got.fault !== want.fault)
                    report_mismatch("page_fault", 32'(got.fault), 32'(want.fault));
                if (got.evicted !== want.evicted)
                    report_mismatch("evicted", 32'(got.evicted), 32'(want.evicted));
                if (got.fault_total !== want.fault_total)
                    report_mismatch("fault_total", got.fault_total, want.fault_total);
            end
        endtask
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [lpt_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [lpt_pkg::M_TDATA_W-1:0] m_tdata;
    logic [lpt_pkg::M_TUSER_W-1:0] m_tuser;

    xlate_scoreboard sb = new();
    int results_seen = 0;
    int idle_cycles = 0;

    lru_page_table_translate_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        xlate_t got;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_access(s_tdata[lpt_pkg::VA_WIDTH-1:0]);
            if (m_tvalid && m_tready) begin
                got.phys_addr   = m_tdata[lpt_pkg::PA_WIDTH-1:0];
                got.fault_total = m_tdata[lpt_pkg::PA_WIDTH+lpt_pkg::COUNT_WIDTH-1:
                                          lpt_pkg::PA_WIDTH];
                got.fault       = m_tuser[0];
                got.evicted     = m_tuser[1];
                sb.check_xlate(got);
                results_seen++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        rx_mode_t mode;
        int       cycle;
        bit       held;
        m_tready <= 1'b0;
        cycle = 0;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && results_seen >= 80) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            cycle++;
            mode = rx_mode_t'((cycle / 97) % 4);
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    task automatic offer(input logic [lpt_pkg::VA_WIDTH-1:0] vaddr);
        s_tvalid <= 1'b1;
        s_tdata  <= {{(lpt_pkg::S_TDATA_W-lpt_pkg::VA_WIDTH){1'b0}}, vaddr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            s_tvalid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [lpt_pkg::VA_WIDTH-1:0] mk_addr(int page, int offset);
        return {page[lpt_pkg::PAGE_NUM_WIDTH-1:0], offset[lpt_pkg::OFFSET_WIDTH-1:0]};
    endfunction

    initial begin
        int burst_left;
        int ws_base;
        int ws_size;
        int page;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes of the address, then hit on page zero, then fill every frame
        offer(12'h000);
        offer(12'hFFF);
        offer(mk_addr(0, 127));
        for (int p = 1; p <= 6; p++)
            offer(mk_addr(p, p * 19));
        // frames full: misses evict the oldest page, then revisit evicted ones
        offer(mk_addr(7, 1));
        offer(mk_addr(31, 64));
        offer(mk_addr(1, 2));
        offer(mk_addr(20, 127));
        offer(mk_addr(0, 0));
        offer(mk_addr(2, 5));
        offer(mk_addr(6, 33));
        offer(mk_addr(31, 0));
        offer(mk_addr(15, 85));
        offer(mk_addr(16, 42));
        drain();

        burst_left = $urandom_range(1, 12);
        ws_base = 0;
        ws_size = 8;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) begin
                ws_base = $urandom_range(0, NUM_PAGES - 1);
                ws_size = $urandom_range(4, 14);
            end
            if ($urandom_range(0, 9) < 7)
                page = (ws_base + $urandom_range(0, ws_size - 1)) % NUM_PAGES;
            else
                page = $urandom_range(0, NUM_PAGES - 1);
            offer(mk_addr(page, $urandom_range(0, 127)));
            if (n == RANDOM_ITEMS / 2) begin
                drain();
            end else begin
                burst_left--;
                if (burst_left == 0) begin
                    idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20));
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                             : $urandom_range(1, 12);
                end
            end
        end

        drain();
        repeat (50) @(posedge aclk);
        if (sb.pending() != 0)
            sb.report_mismatch("missing items", 32'(sb.pending()), 32'(0));
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
